/* sv/sabt_pkg.sv */
// Shared types, constants and command/status structs for the steering assist bias tracker.
`timescale 1ns / 1ps
package sabt_pkg;

  localparam int BIAS_W   = 16;
  localparam int MAG_W    = 15;
  localparam int TIME_W   = 32;
  localparam int LIMIT_W  = 16;
  localparam int MDELTA_W = 7;
  localparam int FAC_W    = 16;
  localparam int PROD_W   = MAG_W + FAC_W;
  localparam int MPROD_W  = MAG_W + MDELTA_W;
  localparam int MSHIFT   = 15;
  localparam int MMAG_W   = MPROD_W - MSHIFT;
  localparam int MOTOR_W  = 8;
  localparam int CFGD_W   = 16;

  localparam logic signed [BIAS_W-1:0] BIAS_LIMIT   = 16'sd16384;
  localparam logic signed [BIAS_W-1:0] BIAS_LIMIT_N = -16'sd16384;

  // Q0.16 decay factors
  localparam logic [FAC_W-1:0] FAC_SAFETY = 16'd32768;
  localparam logic [FAC_W-1:0] FAC_MANUAL = 16'd42598;
  localparam logic [FAC_W-1:0] FAC_DOCK   = 16'd26214;
  localparam logic [FAC_W-1:0] FAC_STALE  = 16'd55706;
  localparam logic [FAC_W-1:0] FAC_FRESH  = 16'd65208;

  localparam logic [MAG_W-1:0] SNAP_SUPP  = 15'd656;
  localparam logic [MAG_W-1:0] SNAP_STALE = 15'd984;
  localparam logic [MAG_W-1:0] SNAP_NONE  = 15'd0;

  localparam logic [MMAG_W-1:0] MOTOR_MIN = 7'd2;

  localparam logic [LIMIT_W-1:0]  STALE_LIMIT_RST = 16'd1600;
  localparam logic [MDELTA_W-1:0] MAX_DELTA_RST   = 7'd22;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_LEFT    = 3'd1,
    ST_RIGHT   = 3'd2,
    ST_CENTER  = 3'd3,
    ST_HOLD    = 3'd4,
    ST_SAFETY  = 3'd5,
    ST_MANUAL  = 3'd6
  } assist_t;

  typedef enum logic [1:0] {
    ZONE_NONE   = 2'd0,
    ZONE_LEFT   = 2'd1,
    ZONE_RIGHT  = 2'd2,
    ZONE_CENTER = 2'd3
  } zone_t;

  typedef enum logic {
    FUNC_MSG  = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef enum logic {
    CFG_STALE_LIMIT = 1'b0,
    CFG_MAX_DELTA   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEL_MSG,
    SEL_SAFETY,
    SEL_MANUAL,
    SEL_DOCK,
    SEL_STALE,
    SEL_FRESH
  } dsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECAY,
    S_APPLY,
    S_MOTOR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic decay;
    logic apply;
    logic motor;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } sts_t;

endpackage

/* sv/sabt_ctrl.sv */
// Sequencer for the bias tracker: steps one item through decay, apply, motor and result load.
`timescale 1ns / 1ps
module sabt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sabt_pkg::sts_t sts,
  output sabt_pkg::cmd_t cmd
);
  import sabt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECAY;
        end
      end
      S_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_MOTOR;
      end
      S_MOTOR: begin
        cmd.motor = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sabt_dp.sv */
// Datapath of the bias tracker: state registers, decay and motor multipliers, result register.
`timescale 1ns / 1ps
module sabt_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sabt_pkg::cmd_t                         cmd,
  output sabt_pkg::sts_t                         sts,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [sabt_pkg::CFGD_W-1:0]            cfg_data,
  input  logic                                   in_func,
  input  logic [sabt_pkg::TIME_W-1:0]            in_time_ms,
  input  logic [1:0]                             in_target_zone,
  input  logic signed [sabt_pkg::BIAS_W-1:0]     in_target_bias,
  input  logic                                   in_target_tracking,
  input  logic                                   in_suppress_safety,
  input  logic                                   in_suppress_manual,
  input  logic                                   in_suppress_dock,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             out_assist_state,
  output logic signed [sabt_pkg::BIAS_W-1:0]     out_turn_bias,
  output logic                                   out_target_stale,
  output logic signed [sabt_pkg::MOTOR_W-1:0]    out_motor_left,
  output logic signed [sabt_pkg::MOTOR_W-1:0]    out_motor_right
);
  import sabt_pkg::*;

  // captured item
  func_t                     func_r;
  logic [TIME_W-1:0]         time_r;
  zone_t                     zone_r;
  logic signed [BIAS_W-1:0]  tbias_r;
  logic                      track_r;
  logic                      ssafe_r;
  logic                      sman_r;
  logic                      sdock_r;

  // tracker state
  logic signed [BIAS_W-1:0]  bias_r;
  assist_t                   mode_r;
  logic [TIME_W-1:0]         last_rx_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic [MDELTA_W-1:0]       mdelta_r;

  // intermediate
  logic [PROD_W-1:0]         prod_r;
  dsel_t                     sel_r;
  logic                      stale_r;
  logic [MPROD_W-1:0]        mot_r;

  // result register
  logic                      out_valid_r;
  assist_t                   out_state_r;
  logic signed [BIAS_W-1:0]  out_bias_r;
  logic                      out_stale_r;
  logic signed [MOTOR_W-1:0] out_left_r;
  logic signed [MOTOR_W-1:0] out_right_r;

  logic [BIAS_W-1:0]         mag16;
  logic [MAG_W-1:0]          bias_mag;
  logic [TIME_W-1:0]         age;
  logic                      stale_now;
  dsel_t                     sel_c;
  logic [FAC_W-1:0]          factor_c;
  logic signed [BIAS_W-1:0]  msg_bias;
  assist_t                   msg_mode;
  logic [MAG_W-1:0]          dmag;
  logic [MAG_W-1:0]          snap_c;
  logic                      snapped;
  logic [BIAS_W-1:0]         dext;
  logic signed [BIAS_W-1:0]  dec_bias;
  logic [MMAG_W-1:0]         mmag;
  logic                      motor_en;
  logic [MOTOR_W-1:0]        mext;
  logic [MOTOR_W-1:0]        left_c;

  assign cfg_ready = 1'b1;

  assign mag16    = bias_r[BIAS_W-1] ? (BIAS_W'(0) - bias_r) : bias_r;
  assign bias_mag = mag16[MAG_W-1:0];

  assign age       = time_r - last_rx_r;
  assign stale_now = (last_rx_r == '0) || (age > {{(TIME_W-LIMIT_W){1'b0}}, limit_r});

  always_comb begin
    if (func_r == FUNC_MSG) begin
      sel_c = SEL_MSG;
    end else if (ssafe_r) begin
      sel_c = SEL_SAFETY;
    end else if (sman_r) begin
      sel_c = SEL_MANUAL;
    end else if (sdock_r) begin
      sel_c = SEL_DOCK;
    end else if (stale_now) begin
      sel_c = SEL_STALE;
    end else begin
      sel_c = SEL_FRESH;
    end
  end

  always_comb begin
    case (sel_c)
      SEL_SAFETY: factor_c = FAC_SAFETY;
      SEL_MANUAL: factor_c = FAC_MANUAL;
      SEL_DOCK:   factor_c = FAC_DOCK;
      SEL_STALE:  factor_c = FAC_STALE;
      SEL_FRESH:  factor_c = FAC_FRESH;
      default:    factor_c = '0;
    endcase
  end

  always_comb begin
    case (sel_r) inside
      SEL_SAFETY, SEL_MANUAL, SEL_DOCK: snap_c = SNAP_SUPP;
      SEL_STALE:                        snap_c = SNAP_STALE;
      default:                          snap_c = SNAP_NONE;
    endcase
  end

  always_comb begin
    if (tbias_r > BIAS_LIMIT) begin
      msg_bias = BIAS_LIMIT;
    end else if (tbias_r < BIAS_LIMIT_N) begin
      msg_bias = BIAS_LIMIT_N;
    end else begin
      msg_bias = tbias_r;
    end
  end

  always_comb begin
    unique case (zone_r)
      ZONE_LEFT:   msg_mode = ST_LEFT;
      ZONE_RIGHT:  msg_mode = ST_RIGHT;
      ZONE_CENTER: msg_mode = ST_CENTER;
      default:     msg_mode = track_r ? ST_HOLD : ST_NONE;
    endcase
  end

  assign dmag     = prod_r[PROD_W-1:FAC_W];
  assign snapped  = dmag < snap_c;
  assign dext     = {{(BIAS_W-MAG_W){1'b0}}, dmag};
  assign dec_bias = snapped ? '0 : (bias_r[BIAS_W-1] ? (BIAS_W'(0) - dext) : dext);

  assign mmag     = mot_r[MPROD_W-1:MSHIFT];
  assign motor_en = !(ssafe_r || sman_r || sdock_r) && !stale_r && (mmag >= MOTOR_MIN);
  assign mext     = {{(MOTOR_W-MMAG_W){1'b0}}, mmag};
  assign left_c   = !motor_en ? '0 : (bias_r[BIAS_W-1] ? (MOTOR_W'(0) - mext) : mext);

  // item capture and intermediates
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= func_t'(in_func);
      time_r  <= in_time_ms;
      zone_r  <= zone_t'(in_target_zone);
      tbias_r <= in_target_bias;
      track_r <= in_target_tracking;
      ssafe_r <= in_suppress_safety;
      sman_r  <= in_suppress_manual;
      sdock_r <= in_suppress_dock;
    end
    if (cmd.decay) begin
      prod_r  <= PROD_W'(bias_mag) * PROD_W'(factor_c);
      sel_r   <= sel_c;
      stale_r <= (func_r == FUNC_MSG) ? (time_r == '0) : stale_now;
    end
    if (cmd.motor) begin
      mot_r <= MPROD_W'(bias_mag) * MPROD_W'(mdelta_r);
    end
  end

  // tracker state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r    <= '0;
      mode_r    <= ST_NONE;
      last_rx_r <= '0;
      limit_r   <= STALE_LIMIT_RST;
      mdelta_r  <= MAX_DELTA_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_STALE_LIMIT: limit_r  <= cfg_data;
          CFG_MAX_DELTA:   mdelta_r <= cfg_data[MDELTA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.decay && func_r == FUNC_MSG) begin
        bias_r    <= msg_bias;
        mode_r    <= msg_mode;
        last_rx_r <= time_r;
      end
      if (cmd.apply && sel_r != SEL_MSG) begin
        bias_r <= dec_bias;
        case (sel_r) inside
          SEL_SAFETY: mode_r <= ST_SAFETY;
          SEL_MANUAL: mode_r <= ST_MANUAL;
          SEL_DOCK, SEL_STALE: begin
            if (snapped) begin
              mode_r <= ST_NONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_state_r <= mode_r;
      out_bias_r  <= bias_r;
      out_stale_r <= stale_r;
      out_left_r  <= left_c;
      out_right_r <= MOTOR_W'(0) - left_c;
    end
  end

  assign sts.out_hold      = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_assist_state  = out_state_r;
  assign out_turn_bias     = out_bias_r;
  assign out_target_stale  = out_stale_r;
  assign out_motor_left    = out_left_r;
  assign out_motor_right   = out_right_r;

  a_bias_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bias_r <= BIAS_LIMIT) && (bias_r >= BIAS_LIMIT_N))
    else $error("bias outside clamp range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_motor_opposed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_right_r == -out_left_r))
    else $error("motor deltas not opposed");

  a_motor_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_left_r != '0) |-> !out_stale_r)
    else $error("motor delta driven while stale");

endmodule

/* sv/steering_assist_bias_tracker_top.sv */
// Top level of the steering assist bias tracker: sequencer plus datapath.
// An input transfer steps through the decay, apply and motor states; the result then goes to
// out_valid once any held result has been taken. No new item is taken before that load; the
// sequencer steps through two registered multiplies (bias decay, then motor delta scaling).
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): bias 0, state none, never received, registers to defaults.
`timescale 1ns / 1ps
module steering_assist_bias_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [sabt_pkg::CFGD_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [sabt_pkg::TIME_W-1:0]         in_time_ms,
  input  logic [1:0]                          in_target_zone,
  input  logic signed [sabt_pkg::BIAS_W-1:0]  in_target_bias,
  input  logic                                in_target_tracking,
  input  logic                                in_suppress_safety,
  input  logic                                in_suppress_manual,
  input  logic                                in_suppress_dock,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_assist_state,
  output logic signed [sabt_pkg::BIAS_W-1:0]  out_turn_bias,
  output logic                                out_target_stale,
  output logic signed [sabt_pkg::MOTOR_W-1:0] out_motor_left,
  output logic signed [sabt_pkg::MOTOR_W-1:0] out_motor_right
);
  import sabt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sabt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sabt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_func            (in_func),
    .in_time_ms         (in_time_ms),
    .in_target_zone     (in_target_zone),
    .in_target_bias     (in_target_bias),
    .in_target_tracking (in_target_tracking),
    .in_suppress_safety (in_suppress_safety),
    .in_suppress_manual (in_suppress_manual),
    .in_suppress_dock   (in_suppress_dock),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_assist_state   (out_assist_state),
    .out_turn_bias      (out_turn_bias),
    .out_target_stale   (out_target_stale),
    .out_motor_left     (out_motor_left),
    .out_motor_right    (out_motor_right)
  );

endmodule
